// ===== hdl/ldrs_pkg.sv =====
// Package for the LOOK disk request scheduler: types, constants, helpers.
`default_nettype none
package ldrs_pkg;
	localparam int QueueDepth = 16;
	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	typedef enum logic {
		OP_ARRIVAL = 1'b0,
		OP_COMPLETE = 1'b1
	} op_t;

	typedef struct packed {
		logic [15:0] process;
		logic [31:0] address;
		logic [15:0] cylinder;
		logic [31:0] arrival;
		logic [15:0] id;
	} req_t;

	// candidate travelling along the chain: class 0 = at head, 1 = ahead,
	// 2 = behind, 3 = none
	typedef struct packed {
		logic [1:0]  cls;
		logic [15:0] span;
		logic [31:0] arrival;
		logic [IdxW-1:0] idx;
	} cand_t;

	typedef struct packed {
		logic        shift;
		logic        load;
		logic [IdxW-1:0] pos;
		logic [15:0] head;
		logic        up;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_OUT
	} state_t;

	function automatic logic better(input cand_t a, input cand_t b);
		// a strictly beats b
		if (a.cls != b.cls) return a.cls < b.cls;
		if (a.span != b.span) return a.span < b.span;
		return a.arrival < b.arrival;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/ldrs_cell.sv =====
// One queue slot: holds a request, shifts toward slot 0, compares during scan.
`default_nettype none
module ldrs_cell (
	input  wire logic                   clk,
	input  wire ldrs_pkg::cell_ctl_t    ctl,
	input  wire logic [ldrs_pkg::IdxW-1:0] my_idx,
	input  wire logic                   occupied,
	input  wire ldrs_pkg::req_t         new_req,
	input  wire ldrs_pkg::req_t         next_req,
	output ldrs_pkg::req_t              req,
	input  wire ldrs_pkg::cand_t        cand_in,
	output ldrs_pkg::cand_t             cand_out
);
	ldrs_pkg::req_t req_q;
	ldrs_pkg::cand_t mine;
	logic [15:0] c;

	assign req = req_q;
	assign c = req_q.cylinder;

	always_comb begin
		mine.idx = my_idx;
		mine.arrival = req_q.arrival;
		mine.span = (c >= ctl.head) ? c - ctl.head : ctl.head - c;
		if (!occupied) begin
			mine.cls = 2'd3;
		end else if (c == ctl.head) begin
			mine.cls = 2'd0;
		end else if ((c > ctl.head) == ctl.up) begin
			mine.cls = 2'd1;
		end else begin
			mine.cls = 2'd2;
		end
		cand_out = ldrs_pkg::better(mine, cand_in) ? mine : cand_in;
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ctl.pos == my_idx) begin
			req_q <= new_req;
		end else if (ctl.shift && my_idx >= ctl.pos) begin
			req_q <= next_req;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/look_disk_request_scheduler_unit.sv =====
// Top level of the LOOK disk request scheduler.
// Arrival, or completion on an empty queue: idle goes straight to the output state,
// where the result registers. Completion: all QueueDepth cells are scanned one per
// cycle, then the shift state, then the output state; one item at a time.
// The next input beat is taken once the state returns to idle after the result registers.
// Reset (arst_n low, async) empties the queue and clears the served request.
`default_nettype none
module look_disk_request_scheduler_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// op[0], id[16:1], arrival[48:17], cylinder[64:49], address[96:65],
	// process[112:97], head[128:113], up[129], zero pad to 136
	input  wire logic [135:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_valid[0], id[16:1], arrival[48:17], cylinder[64:49],
	// address[96:65], process[112:97], dropped[113], zero pad to 120
	output logic [119:0]      m_tdata
);
	localparam int D = ldrs_pkg::QueueDepth;
	localparam int IW = ldrs_pkg::IdxW;
	localparam int CW = ldrs_pkg::CntW;

	ldrs_pkg::state_t state_q, state_d;
	ldrs_pkg::req_t serv_q, in_req, new_q;
	ldrs_pkg::req_t reqs [D];
	ldrs_pkg::cand_t chain [D];
	ldrs_pkg::cand_t best_q;
	ldrs_pkg::cell_ctl_t ctl;
	logic [CW-1:0] count_q;
	logic [IW-1:0] step_q, pos_q;
	logic [15:0] head_q;
	logic up_q, drop_q, load_q;
	logic [119:0] data_q;
	ldrs_pkg::op_t op;

	assign op = ldrs_pkg::op_t'(s_tdata[0]);
	assign in_req.id = s_tdata[16:1];
	assign in_req.arrival = s_tdata[48:17];
	assign in_req.cylinder = s_tdata[64:49];
	assign in_req.address = s_tdata[96:65];
	assign in_req.process = s_tdata[112:97];

	logic acc;
	assign s_tready = (state_q == ldrs_pkg::ST_IDLE);
	assign acc = s_tvalid && s_tready;

	logic arr_ok, take_new, enq, drop_new;
	assign arr_ok = acc && op == ldrs_pkg::OP_ARRIVAL && in_req.id != '0;
	assign take_new = arr_ok && serv_q.id == '0;
	assign enq = arr_ok && serv_q.id != '0 && count_q != CW'(D);
	assign drop_new = arr_ok && serv_q.id != '0 && count_q == CW'(D);

	assign m_tdata = data_q;

	// scan: one cell compares per cycle, best candidate registered
	ldrs_pkg::cand_t none_c;
	assign none_c = '{cls: 2'd3, span: '0, arrival: '0, idx: '0};

	always_comb begin
		ctl.shift = (state_q == ldrs_pkg::ST_SHIFT);
		ctl.load = load_q;
		ctl.pos = load_q ? pos_q : best_q.idx;
		ctl.head = head_q;
		ctl.up = up_q;
	end

	genvar g;
	generate
		for (g = 0; g < D; g++) begin : g_cell
			ldrs_pkg::cand_t cin, cout;
			assign cin = best_q;
			assign chain[g] = cout;
			ldrs_cell u_cell (
				.clk(clk), .ctl(ctl),
				.my_idx(IW'(g)),
				.occupied(CW'(g) < count_q),
				.new_req(new_q),
				.next_req((g == D-1) ? reqs[g] : reqs[(g+1) % D]),
				.req(reqs[g]),
				.cand_in(cin), .cand_out(cout)
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ldrs_pkg::ST_IDLE: if (acc) begin
				state_d = (op == ldrs_pkg::OP_COMPLETE && count_q != '0) ?
					ldrs_pkg::ST_SCAN : ldrs_pkg::ST_OUT;
			end
			ldrs_pkg::ST_SCAN: if (step_q == IW'(D-1)) state_d = ldrs_pkg::ST_SHIFT;
			ldrs_pkg::ST_SHIFT: state_d = ldrs_pkg::ST_OUT;
			ldrs_pkg::ST_OUT: if (!m_tvalid || m_tready) state_d = ldrs_pkg::ST_IDLE;
			default: state_d = ldrs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldrs_pkg::ST_IDLE;
			count_q <= '0;
			serv_q <= '0;
			new_q <= '0;
			step_q <= '0;
			load_q <= 1'b0;
			drop_q <= 1'b0;
			m_tvalid <= 1'b0;
			data_q <= '0;
			best_q <= '0;
			pos_q <= '0;
			head_q <= '0;
			up_q <= 1'b0;
		end else begin
			state_q <= state_d;
			load_q <= enq;
			if (state_q == ldrs_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
				data_q <= {6'd0, drop_q, serv_q.process, serv_q.address,
					serv_q.cylinder, serv_q.arrival, serv_q.id, serv_q.id != '0};
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ldrs_pkg::ST_IDLE: if (acc) begin
					drop_q <= drop_new;
					head_q <= s_tdata[128:113];
					up_q <= s_tdata[129];
					step_q <= '0;
					best_q <= none_c;
					if (take_new) begin
						serv_q <= in_req;
					end else if (op == ldrs_pkg::OP_COMPLETE && count_q == '0) begin
						serv_q <= '0;
					end
					if (enq) begin
						new_q <= in_req;
						pos_q <= count_q[IW-1:0];
						count_q <= count_q + 1'b1;
					end
				end
				ldrs_pkg::ST_SCAN: begin
					if (ldrs_pkg::better(chain[step_q], best_q)) best_q <= chain[step_q];
					step_q <= step_q + 1'b1;
				end
				ldrs_pkg::ST_SHIFT: begin
					serv_q <= reqs[best_q.idx];
					count_q <= count_q - 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
